>>> hdl/pn2d_pkg.sv
// ----------------------------------------------------------------------------
// pn2d_pkg: shared definitions for the 2D Perlin noise block
// Fixed-point widths, operation codes, fade constants and the gradient lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package pn2d_pkg;

  // Fixed-point format and table geometry.
  localparam int FRAC_BITS  = 16;
  localparam int TABLE_BITS = 8;
  localparam int TABLE_SIZE = 2 ** TABLE_BITS;
  localparam int COORD_W    = 32;
  localparam int SCALE_W    = 24;
  localparam int HEIGHT_W   = 19;

  // Stream widths, padded to whole bytes.
  localparam int S_DATA_W = 80;
  localparam int M_DATA_W = 24;

  // Scale register reset value, 0.34 in Q8.16.
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(22282);

  // Operation codes carried in tuser.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // Fade polynomial constants, scaled by 2^FRAC_BITS.
  localparam logic signed [FRAC_BITS+5:0] FADE_K15 = (FRAC_BITS+6)'(15 * (2 ** FRAC_BITS));
  localparam logic signed [FRAC_BITS+5:0] FADE_K10 = (FRAC_BITS+6)'(10 * (2 ** FRAC_BITS));
  localparam logic signed [FRAC_BITS+1:0] ONE_FX   = (FRAC_BITS+2)'(2 ** FRAC_BITS);

  // Gradient codes that reuse dx as the second term.
  localparam logic [3:0] GRAD_H12 = 4'd12;
  localparam logic [3:0] GRAD_H14 = 4'd14;

  // Improved-noise gradient dot product for one lattice corner.
  function automatic logic signed [FRAC_BITS+2:0] grad(
    input logic [3:0]                  h,
    input logic signed [FRAC_BITS+1:0] dx,
    input logic signed [FRAC_BITS+1:0] dy
  );
    logic signed [FRAC_BITS+2:0] gu;
    logic signed [FRAC_BITS+2:0] gv;
    logic signed [FRAC_BITS+2:0] gs;
    gu = h[3] ? dy : dx;
    if (h[3:2] == 2'b00) begin
      gv = dy;
    end else if (h == GRAD_H12 || h == GRAD_H14) begin
      gv = dx;
    end else begin
      gv = '0;
    end
    gs = gu + gv;
    return h[0] ? -gs : gs;
  endfunction

endpackage

`default_nettype wire

>>> hdl/perlin_noise_2d_top.sv
// ----------------------------------------------------------------------------
// perlin_noise_2d_top: pipelined 2D improved Perlin noise
// Table-load and evaluate beats in, signed Q2.16 heights out.
// ----------------------------------------------------------------------------
// The block takes one beat per clock while not stalled and returns one height per
// evaluate beat; m_tvalid rises when that height reaches the output register.
// Table-load beats return nothing. The permutation table lives in three
// synchronous copies: one read at the two x corners, two read at the four hashed
// corners. Each load beat writes each copy as it passes that copy's read stage,
// so every evaluate beat sees exactly the loads that came before it. The whole
// pipeline stalls only while a finished height waits at the output. Load all 256
// table entries before evaluating.
`default_nettype none

module perlin_noise_2d_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Input beat: tdata = entry_index[7:0], entry_value[15:8],
  // x_coord[47:16], y_coord[79:48]; tuser = op.
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [pn2d_pkg::S_DATA_W-1:0]  s_tdata,
  input  wire logic                           s_tuser,
  // Output beat: tdata = height[18:0], zero padded.
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [pn2d_pkg::M_DATA_W-1:0]       m_tdata,
  // Scale register write.
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [pn2d_pkg::SCALE_W-1:0]   cfg_data
);

  localparam int FB = pn2d_pkg::FRAC_BITS;
  localparam int TB = pn2d_pkg::TABLE_BITS;
  localparam int CW = pn2d_pkg::COORD_W;
  localparam int SW = pn2d_pkg::SCALE_W;
  localparam int PW = CW + SW + 1;

  logic en;
  logic [SW-1:0] scale;

  // Stage 1: registered input beat.
  logic v1, op1;
  logic [TB-1:0] idx1, val1;
  logic signed [CW-1:0] x1, y1;
  // Stage 2: scaled coordinates.
  logic v2, op2;
  logic [TB-1:0] idx2, val2;
  logic signed [PW-1:0] px2, py2;
  // Stage 3: cells and fractions, x corner lookups.
  logic v3, op3;
  logic [TB-1:0] idx3, val3, cy3, pa0, pa1;
  logic [FB-1:0] fx3, fy3;
  // Stage 4: fade partials, hashed corners.
  logic ev4;
  logic [FB-1:0] fx4, fy4, tx2, ty2;
  logic signed [FB+5:0] mx4, my4;
  logic [TB-1:0] h00, h01, h10, h11;
  // Stage 5: gradients and fade terms.
  logic ev5;
  logic [FB-1:0] tx3, ty3;
  logic signed [FB+5:0] polyx5, polyy5;
  logic signed [FB+2:0] g00_5, g01_5, g10_5, g11_5;
  // Stage 6: fade weights.
  logic ev6;
  logic signed [FB+1:0] u6, v6;
  logic signed [FB+2:0] g00_6, g01_6, g10_6, g11_6;
  // Stage 7: x lerp products.
  logic ev7;
  logic signed [2*FB+5:0] d0_7, d1_7;
  logic signed [FB+2:0] g00_7, g01_7;
  logic signed [FB+1:0] v7;
  // Stage 8: low and high rows.
  logic ev8;
  logic signed [FB+5:0] low8, high8;
  logic signed [FB+1:0] v8;
  // Stage 9: y lerp product.
  logic ev9;
  logic signed [2*FB+8:0] e9;
  logic signed [FB+5:0] low9;
  // Output register.
  logic [pn2d_pkg::HEIGHT_W-1:0] height_r;

  // Permutation table copies.
  logic [TB-1:0] mem_a  [0:pn2d_pkg::TABLE_SIZE-1];
  logic [TB-1:0] mem_b0 [0:pn2d_pkg::TABLE_SIZE-1];
  logic [TB-1:0] mem_b1 [0:pn2d_pkg::TABLE_SIZE-1];

  // Pipeline advances unless a finished height is held at the output.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign cfg_ready = 1'b1;
  assign m_tdata  = {{(pn2d_pkg::M_DATA_W - pn2d_pkg::HEIGHT_W){1'b0}}, height_r};

  // Scale register.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= pn2d_pkg::SCALE_RESET;
    end else if (cfg_valid) begin
      scale <= cfg_data;
    end
  end

  // Valid and opcode chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      ev4 <= 1'b0; ev5 <= 1'b0; ev6 <= 1'b0; ev7 <= 1'b0; ev8 <= 1'b0; ev9 <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v1  <= s_tvalid;
      v2  <= v1;
      v3  <= v2;
      ev4 <= v3 && (op3 == pn2d_pkg::OP_EVAL);
      ev5 <= ev4;
      ev6 <= ev5;
      ev7 <= ev6;
      ev8 <= ev7;
      ev9 <= ev8;
      m_tvalid <= ev9;
    end
  end

  // Stages 1 and 2: capture the beat and scale both coordinates.
  always_ff @(posedge clk) begin
    if (en) begin
      op1  <= s_tuser;
      idx1 <= s_tdata[7:0];
      val1 <= s_tdata[15:8];
      x1   <= $signed(s_tdata[47:16]);
      y1   <= $signed(s_tdata[79:48]);
      op2  <= op1;
      idx2 <= idx1;
      val2 <= val1;
      px2  <= x1 * $signed({1'b0, scale});
      py2  <= y1 * $signed({1'b0, scale});
    end
  end

  // Stage 3: split into cell and fraction; first table copy.
  logic [TB-1:0] cx2, cx2_inc;
  assign cx2     = px2[2*FB+TB-1:2*FB];
  assign cx2_inc = cx2 + TB'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      op3  <= op2;
      idx3 <= idx2;
      val3 <= val2;
      cy3  <= py2[2*FB+TB-1:2*FB];
      fx3  <= px2[2*FB-1:FB];
      fy3  <= py2[2*FB-1:FB];
      if (v2 && op2 == pn2d_pkg::OP_WRITE) begin
        mem_a[idx2] <= val2;
      end
      pa0 <= mem_a[cx2];
      pa1 <= mem_a[cx2_inc];
    end
  end

  // Stage 4: hash addresses and fade first products.
  logic [TB-1:0] a00, a01, a10, a11;
  assign a00 = pa0 + cy3;
  assign a01 = pa0 + cy3 + TB'(1);
  assign a10 = pa1 + cy3;
  assign a11 = pa1 + cy3 + TB'(1);

  logic signed [FB+5:0]   tx_e, ty_e, kx, ky;
  logic signed [2*FB+11:0] mx_p, my_p;
  logic [2*FB-1:0]        tx2_p, ty2_p;
  assign tx_e  = $signed({6'b0, fx3});
  assign ty_e  = $signed({6'b0, fy3});
  assign kx    = (tx_e <<< 2) + (tx_e <<< 1) - pn2d_pkg::FADE_K15;
  assign ky    = (ty_e <<< 2) + (ty_e <<< 1) - pn2d_pkg::FADE_K15;
  assign mx_p  = tx_e * kx;
  assign my_p  = ty_e * ky;
  assign tx2_p = fx3 * fx3;
  assign ty2_p = fy3 * fy3;

  always_ff @(posedge clk) begin
    if (en) begin
      fx4 <= fx3;
      fy4 <= fy3;
      mx4 <= $signed(mx_p[2*FB+5:FB]);
      my4 <= $signed(my_p[2*FB+5:FB]);
      tx2 <= tx2_p[2*FB-1:FB];
      ty2 <= ty2_p[2*FB-1:FB];
      if (v3 && op3 == pn2d_pkg::OP_WRITE) begin
        mem_b0[idx3] <= val3;
        mem_b1[idx3] <= val3;
      end
      h00 <= mem_b0[a00];
      h01 <= mem_b0[a01];
      h10 <= mem_b1[a10];
      h11 <= mem_b1[a11];
    end
  end

  // Stage 5: corner gradients, cubic term and fade polynomial.
  logic signed [FB+1:0] dx0, dx1, dy0, dy1;
  logic [2*FB-1:0]      tx3_p, ty3_p;
  assign dx0   = $signed({2'b00, fx4});
  assign dy0   = $signed({2'b00, fy4});
  assign dx1   = dx0 - pn2d_pkg::ONE_FX;
  assign dy1   = dy0 - pn2d_pkg::ONE_FX;
  assign tx3_p = tx2 * fx4;
  assign ty3_p = ty2 * fy4;

  always_ff @(posedge clk) begin
    if (en) begin
      tx3    <= tx3_p[2*FB-1:FB];
      ty3    <= ty3_p[2*FB-1:FB];
      polyx5 <= mx4 + pn2d_pkg::FADE_K10;
      polyy5 <= my4 + pn2d_pkg::FADE_K10;
      g00_5  <= pn2d_pkg::grad(h00[3:0], dx0, dy0);
      g10_5  <= pn2d_pkg::grad(h10[3:0], dx1, dy0);
      g01_5  <= pn2d_pkg::grad(h01[3:0], dx0, dy1);
      g11_5  <= pn2d_pkg::grad(h11[3:0], dx1, dy1);
    end
  end

  // Stage 6: fade weights.
  logic signed [2*FB+6:0] u_p, v_p;
  assign u_p = $signed({1'b0, tx3}) * polyx5;
  assign v_p = $signed({1'b0, ty3}) * polyy5;

  always_ff @(posedge clk) begin
    if (en) begin
      u6    <= $signed(u_p[2*FB+1:FB]);
      v6    <= $signed(v_p[2*FB+1:FB]);
      g00_6 <= g00_5;
      g01_6 <= g01_5;
      g10_6 <= g10_5;
      g11_6 <= g11_5;
    end
  end

  // Stage 7: x lerp products.
  logic signed [FB+3:0] dlo, dhi;
  assign dlo = g10_6 - g00_6;
  assign dhi = g11_6 - g01_6;

  always_ff @(posedge clk) begin
    if (en) begin
      d0_7  <= u6 * dlo;
      d1_7  <= u6 * dhi;
      g00_7 <= g00_6;
      g01_7 <= g01_6;
      v7    <= v6;
    end
  end

  // Stage 8: low and high rows.
  always_ff @(posedge clk) begin
    if (en) begin
      low8  <= g00_7 + $signed(d0_7[2*FB+5:FB]);
      high8 <= g01_7 + $signed(d1_7[2*FB+5:FB]);
      v8    <= v7;
    end
  end

  // Stage 9: y lerp product.
  logic signed [FB+6:0] dy_row;
  assign dy_row = high8 - low8;

  always_ff @(posedge clk) begin
    if (en) begin
      e9   <= v8 * dy_row;
      low9 <= low8;
    end
  end

  // Output register: final blend.
  logic signed [FB+8:0] h_sum;
  assign h_sum = low9 + $signed(e9[2*FB+8:FB]);

  always_ff @(posedge clk) begin
    if (en) begin
      height_r <= h_sum[pn2d_pkg::HEIGHT_W-1:0];
    end
  end

  // A stall freezes every stage.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable({v1, v2, v3, ev4, ev5, ev6, ev7, ev8, ev9}))
    else $error("pipeline moved during a stall");

  // Heights stay within -2.0 .. +2.0.
  a_height_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(height_r) >= -(2 ** (FB + 1)) &&
                  $signed(height_r) <= (2 ** (FB + 1))))
    else $error("height out of range");

  // The scale register changes only on a configuration write.
  a_scale_write: assert property (@(posedge clk) disable iff (rst)
    !cfg_valid |=> $stable(scale))
    else $error("scale changed without a write");

endmodule

`default_nettype wire

>>> dv/perlin_noise_2d_top_test.sv
// ----------------------------------------------------------------------------
// perlin_noise_2d_top_test: self-checking test of the 2D Perlin noise block
// Loads the permutation table, evaluates directed and random points under
// several scale settings and stall patterns, and compares every height beat
// with a fixed-point prediction kept alongside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module perlin_noise_2d_top_test;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 30;
  localparam int FB             = pn2d_pkg::FRAC_BITS;
  localparam int HW             = pn2d_pkg::HEIGHT_W;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [pn2d_pkg::S_DATA_W-1:0] s_tdata;
  logic s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [pn2d_pkg::M_DATA_W-1:0] m_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [pn2d_pkg::SCALE_W-1:0] cfg_data;

  // Predictor state: the table and scale as the block should hold them.
  logic [7:0] perm_copy [pn2d_pkg::TABLE_SIZE];
  logic [pn2d_pkg::SCALE_W-1:0] scale_copy;
  logic signed [HW-1:0] height_queue [$];

  // Percent of cycles each side stays idle.
  int send_idle_pct;
  int recv_stall_pct;
  int fail_count = 0;
  int quiet_cycles = 0;

  perlin_noise_2d_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Floor of v / 2^FRAC_BITS; arithmetic shift rounds toward minus infinity.
  function automatic longint trunc_fx(input longint v);
    return v >>> FB;
  endfunction

  function automatic longint fade_curve(input longint t);
    longint poly;
    longint cube;
    poly = trunc_fx(t * (6 * t - 15 * (64'sd1 <<< FB))) + 10 * (64'sd1 <<< FB);
    cube = trunc_fx(trunc_fx(t * t) * t);
    return trunc_fx(cube * poly);
  endfunction

  function automatic longint corner_dot(input logic [7:0] hv, input longint dx,
                                        input longint dy);
    logic [3:0] h;
    longint gu;
    longint gv;
    h = hv[3:0];
    gu = (h < 8) ? dx : dy;
    gv = (h < 4) ? dy :
         ((h == pn2d_pkg::GRAD_H12 || h == pn2d_pkg::GRAD_H14) ? dx : 0);
    return h[0] ? -(gu + gv) : (gu + gv);
  endfunction

  // Scale one coordinate and split it into lattice cell and fraction.
  function automatic void split_point(input logic signed [31:0] c,
                                      output logic [7:0] lat_cell, output longint frac);
    longint prod;
    prod = longint'(c) * longint'({40'd0, scale_copy});
    prod = prod >>> FB;
    frac = prod & ((64'sd1 <<< FB) - 1);
    lat_cell = 8'(prod >>> FB);
  endfunction

  function automatic logic signed [HW-1:0] noise_height(input logic signed [31:0] xc,
                                                         input logic signed [31:0] yc);
    logic [7:0] cx, cy, px0, px1, h00, h01, h10, h11;
    longint fx, fy, u, v, lo, hi, one;
    one = 64'sd1 <<< FB;
    split_point(xc, cx, fx);
    split_point(yc, cy, fy);
    u = fade_curve(fx);
    v = fade_curve(fy);
    px0 = perm_copy[cx];
    px1 = perm_copy[8'(cx + 8'd1)];
    h00 = perm_copy[8'(px0 + cy)];
    h01 = perm_copy[8'(px0 + cy + 8'd1)];
    h10 = perm_copy[8'(px1 + cy)];
    h11 = perm_copy[8'(px1 + cy + 8'd1)];
    lo = corner_dot(h00, fx, fy);
    lo = lo + trunc_fx(u * (corner_dot(h10, fx - one, fy) - lo));
    hi = corner_dot(h01, fx, fy - one);
    hi = hi + trunc_fx(u * (corner_dot(h11, fx - one, fy - one) - hi));
    return HW'(lo + trunc_fx(v * (hi - lo)));
  endfunction

  // Send one beat, with random idle cycles ahead of it.
  task automatic send_beat(input logic op, input logic [7:0] idx, input logic [7:0] val,
                           input logic [31:0] xc, input logic [31:0] yc);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {yc, xc, val, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op == pn2d_pkg::OP_WRITE) begin
      perm_copy[idx] = val;
    end else begin
      height_queue.push_back(noise_height(xc, yc));
    end
  endtask

  task automatic send_eval(input logic [31:0] xc, input logic [31:0] yc);
    send_beat(pn2d_pkg::OP_EVAL, 8'($urandom), 8'($urandom), xc, yc);
  endtask

  task automatic go_quiet();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (height_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_scale(input logic [pn2d_pkg::SCALE_W-1:0] value);
    go_quiet();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    scale_copy = value;
  endtask

  // Load every table entry; a shuffled table or a random one.
  task automatic test_table_load(input bit shuffled);
    logic [7:0] order [pn2d_pkg::TABLE_SIZE];
    int j;
    logic [7:0] t;
    for (int i = 0; i < pn2d_pkg::TABLE_SIZE; i++) order[i] = 8'(i);
    for (int i = pn2d_pkg::TABLE_SIZE - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < pn2d_pkg::TABLE_SIZE; i++) begin
      send_beat(pn2d_pkg::OP_WRITE, 8'(i), shuffled ? order[i] : 8'($urandom),
                $urandom, $urandom);
    end
  endtask

  // Coordinate extremes, lattice points, fraction edges and mid-stream table rewrites.
  task automatic test_directed_points();
    send_eval(32'h0000_0000, 32'h0000_0000);
    send_eval(32'h7fff_ffff, 32'h7fff_ffff);
    send_eval(32'h8000_0000, 32'h8000_0000);
    send_eval(32'hffff_ffff, 32'h0000_0001);
    send_eval(32'h0001_0000, 32'hffff_0000);
    send_eval(32'h0000_ffff, 32'h0000_8000);
    send_eval(32'h8000_0000, 32'h7fff_ffff);
    send_eval(32'h00ff_ffff, 32'hff00_0001);
    send_eval(32'h5555_5555, 32'haaaa_aaaa);
    for (int h = 0; h < 16; h++) begin
      // Table entry rewrite in mid-stream, then a point that reads it at small scales.
      send_beat(pn2d_pkg::OP_WRITE, 8'd0, 8'(h), $urandom, $urandom);
      send_eval(32'(h * 4096), 32'(h * 3000));
    end
  endtask

  // Random evaluations mixed with occasional table rewrites.
  task automatic test_random_points(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) begin
        send_beat(pn2d_pkg::OP_WRITE, 8'($urandom), 8'($urandom), $urandom, $urandom);
      end else if ($urandom_range(3) == 0) begin
        send_eval(32'($signed($urandom_range(65535)) - 32768),
                  32'($signed($urandom_range(65535)) - 32768));
      end else begin
        send_eval($urandom, $urandom);
      end
    end
  endtask

  // Random receiver stalls.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check every height beat against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (height_queue.size() == 0) begin
        $error("height: beat with no prediction, actual %0d",
               $signed(m_tdata[HW-1:0]));
        fail_count++;
      end else if (m_tdata[HW-1:0] !== height_queue[0]) begin
        $error("height: expected %0d, actual %0d", height_queue[0],
               $signed(m_tdata[HW-1:0]));
        fail_count++;
        void'(height_queue.pop_front());
      end else begin
        void'(height_queue.pop_front());
      end
    end
  end

  // Watchdog on cycles with no accepted beat of any kind.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    scale_copy = pn2d_pkg::SCALE_RESET;
    for (int i = 0; i < pn2d_pkg::TABLE_SIZE; i++) perm_copy[i] = 8'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_table_load(1'b1);
    test_directed_points();
    write_scale(24'h00_0000);
    test_directed_points();
    write_scale(24'hff_ffff);
    test_directed_points();
    write_scale(24'h01_0000);
    test_random_points(30);

    send_idle_pct = 50;
    test_random_points(40);
    write_scale(24'($urandom));
    recv_stall_pct = 50;
    send_idle_pct = 0;
    test_random_points(40);
    go_quiet();
    test_table_load(1'b0);
    send_idle_pct = 20;
    recv_stall_pct = 20;
    test_random_points(40);
    write_scale(pn2d_pkg::SCALE_RESET);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_points(40);

    go_quiet();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
